// ===== sv/mi3_pkg.sv =====
// Package for the 3x3 matrix inverse: field widths, register reset value and
// the side-band struct that rides along the divider pipeline.
// No dependencies.
package mi3_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int SUBST_W       = 31;
	localparam logic [SUBST_W-1:0] SUBST_RESET = 31'd655;
	localparam int N_ELEM        = 9;
	localparam int PROD_W        = 64;  // 32x32 signed product
	localparam int COF_W         = 65;  // 2x2 cofactor, signed
	localparam int MAG_W         = 64;  // cofactor magnitude
	localparam int PART_W        = 65;  // row-0 element times cofactor half
	localparam int PSUM_W        = 67;  // sum of three partials
	localparam int DET_W         = 97;  // full determinant, signed
	localparam int FRONT_STAGES  = 6;
	localparam int DIV_STAGES    = DATA_W + 1;

	typedef struct packed {
		logic              sing;
		logic [N_ELEM-1:0] qneg;
	} side_t;

endpackage

// ===== sv/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse, adjugate over exact determinant, signed Q16.16.
// The path runs through 6 front stages, 33 divider stages and an output register.
// Throughput: one matrix per cycle while the skid entry is free (in_stall low).
// The divider's one quotient bit per stage sets the depth.
// Reset clears all valid bits and sets the singular substitute to 655.
module matrix_inverse_3x3 #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mi3_pkg::SUBST_W-1:0]          cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [mi3_pkg::DATA_W-1:0]    a_r0c0,
	input  logic signed [mi3_pkg::DATA_W-1:0]    a_r0c1,
	input  logic signed [mi3_pkg::DATA_W-1:0]    a_r0c2,
	input  logic signed [mi3_pkg::DATA_W-1:0]    a_r1c0,
	input  logic signed [mi3_pkg::DATA_W-1:0]    a_r1c1,
	input  logic signed [mi3_pkg::DATA_W-1:0]    a_r1c2,
	input  logic signed [mi3_pkg::DATA_W-1:0]    a_r2c0,
	input  logic signed [mi3_pkg::DATA_W-1:0]    a_r2c1,
	input  logic signed [mi3_pkg::DATA_W-1:0]    a_r2c2,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [mi3_pkg::DATA_W-1:0]    b_r0c0,
	output logic signed [mi3_pkg::DATA_W-1:0]    b_r0c1,
	output logic signed [mi3_pkg::DATA_W-1:0]    b_r0c2,
	output logic signed [mi3_pkg::DATA_W-1:0]    b_r1c0,
	output logic signed [mi3_pkg::DATA_W-1:0]    b_r1c1,
	output logic signed [mi3_pkg::DATA_W-1:0]    b_r1c2,
	output logic signed [mi3_pkg::DATA_W-1:0]    b_r2c0,
	output logic signed [mi3_pkg::DATA_W-1:0]    b_r2c1,
	output logic signed [mi3_pkg::DATA_W-1:0]    b_r2c2,
	output logic                                 singular,
	output logic                                 saturated
);

	localparam int DW     = mi3_pkg::DATA_W;
	localparam int NE     = mi3_pkg::N_ELEM;
	localparam int PROD_W = mi3_pkg::PROD_W;
	localparam int COF_W  = mi3_pkg::COF_W;
	localparam int MAG_W  = mi3_pkg::MAG_W;
	localparam int PART_W = mi3_pkg::PART_W;
	localparam int PSUM_W = mi3_pkg::PSUM_W;
	localparam int DET_W  = mi3_pkg::DET_W;
	localparam int SUBST_W = mi3_pkg::SUBST_W;
	localparam int DMAG_W = (SUBST_W + 2 * FRAC_BITS > DET_W - 1) ?
	                        SUBST_W + 2 * FRAC_BITS : DET_W - 1;
	localparam int PIPE_N = mi3_pkg::FRONT_STAGES + mi3_pkg::DIV_STAGES;

	localparam logic [DW-1:0] MIN_NEG = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};

	logic adv;
	logic [SUBST_W-1:0] subst_q;
	logic vld_s [1:PIPE_N];

	logic signed [DW-1:0] a_in [NE];

	assign a_in[0] = a_r0c0;
	assign a_in[1] = a_r0c1;
	assign a_in[2] = a_r0c2;
	assign a_in[3] = a_r1c0;
	assign a_in[4] = a_r1c1;
	assign a_in[5] = a_r1c2;
	assign a_in[6] = a_r2c0;
	assign a_in[7] = a_r2c1;
	assign a_in[8] = a_r2c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subst_q <= mi3_pkg::SUBST_RESET;
		end else if (cfg_we) begin
			subst_q <= cfg_wdata;
		end
	end

	// stage 1: the two products of each cofactor of the transpose
	logic signed [PROD_W-1:0] pa_s1 [NE];
	logic signed [PROD_W-1:0] pb_s1 [NE];
	logic signed [DW-1:0]     a0_s1 [3];

	for (genvar e = 0; e < NE; e++) begin : g_prod
		localparam int BI = e / 3;
		localparam int BJ = e % 3;
		localparam int R1 = (BJ + 1) % 3;
		localparam int R2 = (BJ + 2) % 3;
		localparam int C1 = (BI + 1) % 3;
		localparam int C2 = (BI + 2) % 3;

		always_ff @(posedge clk) begin
			if (adv) begin
				pa_s1[e] <= PROD_W'(a_in[R1*3+C1]) * PROD_W'(a_in[R2*3+C2]);
				pb_s1[e] <= PROD_W'(a_in[R1*3+C2]) * PROD_W'(a_in[R2*3+C1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				a0_s1[k] <= a_in[k];
			end
		end
	end

	// stage 2: cofactors
	logic signed [COF_W-1:0] cof_s2 [NE];
	logic signed [DW-1:0]    a0_s2  [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int e = 0; e < NE; e++) begin
				cof_s2[e] <= COF_W'(pa_s1[e]) - COF_W'(pb_s1[e]);
			end
			a0_s2 <= a0_s1;
		end
	end

	// stage 3: cofactor magnitudes; det partials split at bit 32 of the cofactor
	logic [MAG_W-1:0]         cmag_s3 [NE];
	logic [NE-1:0]            cneg_s3;
	logic signed [PART_W-1:0] plo_s3 [3];
	logic signed [PART_W-1:0] phi_s3 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int e = 0; e < NE; e++) begin
				cmag_s3[e] <= cof_s2[e][COF_W-1] ? MAG_W'(-cof_s2[e]) : MAG_W'(cof_s2[e]);
				cneg_s3[e] <= cof_s2[e][COF_W-1];
			end
			// row-0 cofactors sit at elements 0, 3, 6
			for (int k = 0; k < 3; k++) begin
				plo_s3[k] <= PART_W'(a0_s2[k]) *
				             PART_W'($signed({1'b0, cof_s2[k*3][DW-1:0]}));
				phi_s3[k] <= PART_W'(a0_s2[k]) *
				             PART_W'($signed(cof_s2[k*3][COF_W-1:DW]));
			end
		end
	end

	// stage 4: partial sums
	logic signed [PSUM_W-1:0] slo_s4, shi_s4;
	logic [MAG_W-1:0]         cmag_s4 [NE];
	logic [NE-1:0]            cneg_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			slo_s4  <= PSUM_W'(plo_s3[0]) + PSUM_W'(plo_s3[1]) + PSUM_W'(plo_s3[2]);
			shi_s4  <= PSUM_W'(phi_s3[0]) + PSUM_W'(phi_s3[1]) + PSUM_W'(phi_s3[2]);
			cmag_s4 <= cmag_s3;
			cneg_s4 <= cneg_s3;
		end
	end

	// stage 5: full determinant
	logic signed [DET_W-1:0] det_s5;
	logic [MAG_W-1:0]        cmag_s5 [NE];
	logic [NE-1:0]           cneg_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s5  <= (DET_W'(shi_s4) << DW) + DET_W'(slo_s4);
			cmag_s5 <= cmag_s4;
			cneg_s5 <= cneg_s4;
		end
	end

	// stage 6: divisor magnitude, substitute on exact zero
	logic [DMAG_W-1:0]  dmag_s6;
	logic [MAG_W-1:0]   cmag_s6 [NE];
	mi3_pkg::side_t     side_s6;
	logic [SUBST_W-1:0] subst_eff;
	logic               dzero;
	logic               dneg;
	logic [DET_W-1:0]   det_abs;

	always_comb begin
		subst_eff = (subst_q == '0) ? SUBST_W'(1) : subst_q;
		dzero     = det_s5 == '0;
		dneg      = det_s5[DET_W-1];
		det_abs   = dneg ? DET_W'(-det_s5) : DET_W'(det_s5);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dmag_s6      <= dzero ? (DMAG_W'(subst_eff) << (2 * FRAC_BITS)) : DMAG_W'(det_abs);
			cmag_s6      <= cmag_s5;
			side_s6.sing <= dzero;
			side_s6.qneg <= cneg_s5 ^ {NE{dneg}};
		end
	end

	logic [DW-1:0]  quo [NE];
	logic           ovf [NE];
	mi3_pkg::side_t side_d;

	mi3_div #(
		.FRAC_BITS (FRAC_BITS),
		.DMAG_W    (DMAG_W)
	) u_div (
		.clk      (clk),
		.adv      (adv),
		.dmag     (dmag_s6),
		.cmag     (cmag_s6),
		.side_in  (side_s6),
		.quo      (quo),
		.ovf      (ovf),
		.side_out (side_d)
	);

	// sign and saturate
	logic [DW-1:0] res_b [NE];
	logic          res_sat;

	always_comb begin
		res_sat = 1'b0;
		for (int e = 0; e < NE; e++) begin
			if (side_d.qneg[e]) begin
				if (ovf[e] || quo[e] > MIN_NEG) begin
					res_b[e] = MIN_NEG;
					res_sat  = 1'b1;
				end else begin
					res_b[e] = -quo[e];
				end
			end else begin
				if (ovf[e] || quo[e][DW-1]) begin
					res_b[e] = MAX_POS;
					res_sat  = 1'b1;
				end else begin
					res_b[e] = quo[e];
				end
			end
		end
	end

	// pipeline moves as one while the skid entry is free
	logic          out_vld_q, skid_vld_q;
	logic [DW-1:0] ob_q [NE];
	logic [DW-1:0] sb_q [NE];
	logic          osing_q, osat_q, ssing_q, ssat_q;
	logic          pipe_out;
	logic          take;
	logic          load_out;

	assign adv      = !skid_vld_q;
	assign in_stall = skid_vld_q;
	assign pipe_out = vld_s[PIPE_N] && adv;
	assign take     = out_vld_q && !out_stall;
	assign load_out = !out_vld_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= PIPE_N; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= PIPE_N; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q  <= skid_vld_q || pipe_out;
			skid_vld_q <= 1'b0;
		end else if (pipe_out) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (skid_vld_q) begin
				ob_q    <= sb_q;
				osing_q <= ssing_q;
				osat_q  <= ssat_q;
			end else if (pipe_out) begin
				ob_q    <= res_b;
				osing_q <= side_d.sing;
				osat_q  <= res_sat;
			end
		end else if (pipe_out) begin
			sb_q    <= res_b;
			ssing_q <= side_d.sing;
			ssat_q  <= res_sat;
		end
	end

	assign out_valid = out_vld_q;
	assign b_r0c0    = ob_q[0];
	assign b_r0c1    = ob_q[1];
	assign b_r0c2    = ob_q[2];
	assign b_r1c0    = ob_q[3];
	assign b_r1c1    = ob_q[4];
	assign b_r1c2    = ob_q[5];
	assign b_r2c0    = ob_q[6];
	assign b_r2c1    = ob_q[7];
	assign b_r2c2    = ob_q[8];
	assign singular  = osing_q;
	assign saturated = osat_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a beat while output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && out_stall))
		else $error("skid filled without a stalled output beat");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !out_stall |=> out_vld_q && !skid_vld_q)
		else $error("skid beat not moved to output register");

endmodule

// ===== sv/mi3_div.sv =====
// Nine-lane pipelined restoring divider for the inverse elements.
// One overflow check stage, then one quotient bit per stage. Uses mi3_pkg.
module mi3_div #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF,
	parameter int DMAG_W    = mi3_pkg::DET_W - 1
) (
	input  logic                            clk,
	input  logic                            adv,
	input  logic [DMAG_W-1:0]               dmag,
	input  logic [mi3_pkg::MAG_W-1:0]       cmag     [mi3_pkg::N_ELEM],
	input  mi3_pkg::side_t                  side_in,
	output logic [mi3_pkg::DATA_W-1:0]      quo      [mi3_pkg::N_ELEM],
	output logic                            ovf      [mi3_pkg::N_ELEM],
	output mi3_pkg::side_t                  side_out
);

	localparam int NUM_W = mi3_pkg::MAG_W + 2 * FRAC_BITS;
	localparam int HI_W  = NUM_W - mi3_pkg::DATA_W;
	localparam int STEPS = mi3_pkg::DATA_W;
	localparam int NE    = mi3_pkg::N_ELEM;
	localparam int DW    = mi3_pkg::DATA_W;

	logic [DMAG_W-1:0]  rem_s  [0:STEPS-1][NE];
	logic [DW-1:0]      nq_s   [0:STEPS][NE];
	logic               ovf_s  [0:STEPS][NE];
	logic [DMAG_W-1:0]  dmag_s [0:STEPS];
	mi3_pkg::side_t     side_s [0:STEPS];

	logic [NUM_W-1:0]   num [NE];
	logic [HI_W-1:0]    num_hi [NE];

	always_comb begin
		for (int e = 0; e < NE; e++) begin
			num[e]    = {cmag[e], {(2 * FRAC_BITS){1'b0}}};
			num_hi[e] = num[e][NUM_W-1:DW];
		end
	end

	// quotient fits in 32 bits only when num < dmag * 2^32
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int e = 0; e < NE; e++) begin
				rem_s[0][e] <= DMAG_W'(num_hi[e]);
				ovf_s[0][e] <= DMAG_W'(num_hi[e]) >= dmag;
				nq_s[0][e]  <= num[e][DW-1:0];
			end
			dmag_s[0] <= dmag;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		logic [DMAG_W:0] trial [NE];
		logic [DMAG_W:0] diff  [NE];
		logic            ge    [NE];

		always_comb begin
			for (int e = 0; e < NE; e++) begin
				trial[e] = {rem_s[k-1][e], nq_s[k-1][e][DW-1]};
				diff[e]  = trial[e] - {1'b0, dmag_s[k-1]};
				ge[e]    = trial[e] >= {1'b0, dmag_s[k-1]};
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int e = 0; e < NE; e++) begin
					nq_s[k][e]  <= {nq_s[k-1][e][DW-2:0], ge[e]};
					ovf_s[k][e] <= ovf_s[k-1][e];
				end
				dmag_s[k] <= dmag_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end

		if (k < STEPS) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv) begin
					for (int e = 0; e < NE; e++) begin
						rem_s[k][e] <= ge[e] ? diff[e][DMAG_W-1:0] : trial[e][DMAG_W-1:0];
					end
				end
			end
		end
	end

	always_comb begin
		for (int e = 0; e < NE; e++) begin
			quo[e] = nq_s[STEPS][e];
			ovf[e] = ovf_s[STEPS][e];
		end
		side_out = side_s[STEPS];
	end

endmodule
